@@ src/ring_buffer_fifo_defines.svh @@
// Assertion macros used by the ring buffer FIFO module.
`ifndef RING_BUFFER_FIFO_DEFINES_SVH
`define RING_BUFFER_FIFO_DEFINES_SVH

// Clocked property on clk, switched off while rst is high.
`define RBF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Invariant that must hold at every clock edge outside reset.
`define RBF_CHECK(name, cond, msg) \
  `RBF_ASSERT(name, (cond), msg)

`endif

@@ src/rbf_pkg.sv @@
package rbf_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

@@ src/rbf_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module rbf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ring_buffer_fifo.sv @@
// Channel     Handshake                 Payload
// ----------  ------------------------  ---------------------------------------------
// command     start / busy              kind, data_in
// result      done (one-cycle strobe)   data_out, status, fill_count, is_empty, is_full
// config      cfg_valid / cfg_ready     cfg_data (capacity_in_use)
//
// A command is taken on any edge with start high; busy stays low, so one command
// enters every cycle. Its result strobes on done in the very next cycle: the
// storage RAM registers its read data and the pointers, count and flags
// are settled at the accept edge. Reset (rst, synchronous) empties the ring and
// loads a capacity of 16; the stored words stay undefined until pushed. The
// receiver cannot stall, so nothing here ever holds a result back.
`include "ring_buffer_fifo_defines.svh"

module ring_buffer_fifo import rbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            kind,
  input  logic [DATA_WIDTH-1:0] data_in,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_data,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] data_out,
  output logic [1:0]            status,
  output logic [CNT_W-1:0]      fill_count,
  output logic                  is_empty,
  output logic                  is_full
);

  // Step a pointer, wrapping to zero at the configured capacity.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(ptr) + CNT_W'(1);
    return (n >= cap) ? '0 : PTR_W'(n);
  endfunction

  // Control state
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CAP_W-1:0] cap_reg;
  logic             rd_ok, rd_ok_next;

  // Result registers
  status_t          status_r, status_next;
  logic [CNT_W-1:0] fill_r;
  logic             empty_r, full_r;

  logic                  accept;
  logic [CMP_W-1:0]      cap_ext;
  logic [CNT_W-1:0]      eff_cap;
  logic                  full_now;
  logic                  mem_we;
  logic [DATA_WIDTH-1:0] mem_q;

  assign accept    = start && !busy;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Clamp the programmed capacity into 1..DEPTH.
  always_comb begin
    cap_ext = CMP_W'(cap_reg);
    if (cap_ext == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_ext);
    end
  end

  assign full_now = (count >= eff_cap);

  // Decode the transaction; an error leaves every pointer and the count alone.
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    status_next = ST_OK;
    rd_ok_next  = 1'b0;
    mem_we      = 1'b0;
    if (accept) begin
      case (kind_t'(kind))
        KIND_PUSH: begin
          if (full_now) begin
            status_next = ST_OVERFLOW;
          end else begin
            mem_we      = 1'b1;
            wr_ptr_next = advance(wr_ptr, eff_cap);
            count_next  = count + CNT_W'(1);
          end
        end
        KIND_POP, KIND_PEEK: begin
          if (count == '0) begin
            status_next = ST_UNDERFLOW;
          end else begin
            rd_ok_next = 1'b1;
            // Pop consumes the head; peek only looks at it.
            if (kind_t'(kind) == KIND_POP) begin
              rd_ptr_next = advance(rd_ptr, eff_cap);
              count_next  = count - CNT_W'(1);
            end
          end
        end
        KIND_CLEAR: begin
          wr_ptr_next = '0;
          rd_ptr_next = '0;
          count_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Head word is read on every accept; the RAM returns it with the result strobe.
  rbf_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr),
    .wdata (data_in),
    .re    (accept),
    .raddr (rd_ptr),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      cap_reg <= CAP_RESET;
      done    <= 1'b0;
      rd_ok   <= 1'b0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
      done   <= accept;
      rd_ok  <= rd_ok_next;
      if (cfg_valid && cfg_ready) begin
        cap_reg <= cfg_data;
      end
    end
  end

  // Result payload: capture the post-operation view at the accept edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_next;
      fill_r   <= count_next;
      empty_r  <= (count_next == '0);
      full_r   <= (count_next >= eff_cap);
    end
  end

  // Drop the RAM word unless this transaction was a successful pop or peek.
  assign data_out   = rd_ok ? mem_q : '0;
  assign status     = status_r;
  assign fill_count = fill_r;
  assign is_empty   = empty_r;
  assign is_full    = full_r;

  `RBF_ASSERT(a_result_follows, accept |=> done, "accepted command produced no result")
  `RBF_ASSERT(a_no_stray_result, !accept |=> !done, "result strobe without a command")
  `RBF_CHECK(a_count_bound, count <= CNT_W'(DEPTH), "entry count beyond ring depth")
  `RBF_ASSERT(a_overflow_holds,
    (accept && kind == KIND_PUSH && full_now) |=> (count == $past(count) && wr_ptr == $past(wr_ptr)),
    "overflowing push changed the ring")
  `RBF_CHECK(a_flags_exclusive, !(done && is_empty && is_full), "ring reported empty and full")

endmodule
